// File: rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes of the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // op codes on the input port
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_TICKS_PER_UNIT = 2'd0;
  localparam logic [1:0] CFG_ACK_TIMEOUT    = 2'd1;

  // configuration reset values
  localparam logic [7:0] TICKS_PER_UNIT_RST = 8'd1;
  localparam logic [7:0] ACK_TIMEOUT_RST    = 8'd250;

  // decoded command carried from the front to the sequencer
  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ
  } cmd_e;

  // bus sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST_A,
    PH_ST_B,
    PH_SP_A,
    PH_SP_B,
    PH_SP_C,
    PH_WR_LO,
    PH_WR_DT,
    PH_WR_HI,
    PH_WA_LO,
    PH_WA_HI,
    PH_WA_PL,
    PH_RD_LO,
    PH_RD_HI,
    PH_AK_LO,
    PH_AK_HI
  } phase_e;

  // one input item
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_oe;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;
  } res_item_t;

  // classified tick queued for the sequencer
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } tick_t;

  // configuration write
  typedef struct packed {
    logic       valid;
    logic [1:0] index;
    logic [7:0] data;
  } cfg_wr_t;

endpackage

// File: rtl/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts ticks, decodes the op field and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module i2cm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  i2cm_pkg::in_item_t  item_i,
  output logic                tick_valid_o,
  output i2cm_pkg::tick_t     tick_o,
  input  logic                tick_take_i
);
  import i2cm_pkg::*;

  tick_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;
  tick_t      dec;

  // op decode, unused codes run as plain ticks
  always_comb begin
    dec.tx_byte  = item_i.tx_byte;
    dec.send_ack = item_i.send_ack;
    dec.sda_in   = item_i.sda_in;
    case (item_i.op)
      OP_START: dec.cmd = CMD_START;
      OP_STOP:  dec.cmd = CMD_STOP;
      OP_WRITE: dec.cmd = CMD_WRITE;
      OP_READ:  dec.cmd = CMD_READ;
      default:  dec.cmd = CMD_TICK;
    endcase
  end

  // queue control
  assign full         = (cnt_q == 2'd2);
  assign wr_en        = push && !full;
  assign tick_valid_o = (cnt_q != 2'd0);
  assign rd_en        = tick_take_i && tick_valid_o;
  assign tick_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= dec;
    end
  end

endmodule

// File: rtl/i2cm_seq.sv
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus sequencer: advances the SCL/SDA phases by one tick per step.
// ----------------------------------------------------------------------------
module i2cm_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  i2cm_pkg::cfg_wr_t   cfg_i,
  input  logic                tick_valid_i,
  input  i2cm_pkg::tick_t     tick_i,
  output logic                tick_take_o,
  input  logic                res_room_i,
  output logic                res_push_o,
  output i2cm_pkg::res_item_t res_o
);
  import i2cm_pkg::*;

  logic [7:0] ticks_q, timeout_q;
  phase_e     phase_q, phase_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [1:0] dly_q, dly_d;
  logic [7:0] presc_q, presc_d;
  logic [7:0] poll_q, poll_d;
  logic       scl_q, scl_d, sda_q, sda_d, oe_q, oe_d;
  logic       ack_flag_q, ack_flag_d;
  logic       ack_req_q, ack_req_d;
  logic [7:0] rx_q, rx_d;
  logic       stop_err_q, stop_err_d;
  logic       done;
  logic       step;
  logic [1:0] dly_dec;
  logic [8:0] poll_next;

  assign step        = tick_valid_i && res_room_i;
  assign tick_take_o = step;
  assign res_push_o  = step;
  assign dly_dec     = (dly_q != 2'd0) ? dly_q - 2'd1 : dly_q;
  assign poll_next   = {1'b0, poll_q} + 9'd1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q   <= TICKS_PER_UNIT_RST;
      timeout_q <= ACK_TIMEOUT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_TICKS_PER_UNIT: ticks_q   <= cfg_i.data;
        CFG_ACK_TIMEOUT:    timeout_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // next state for one tick
  always_comb begin
    phase_d    = phase_q;
    bit_d      = bit_q;
    shift_d    = shift_q;
    dly_d      = dly_q;
    presc_d    = presc_q;
    poll_d     = poll_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    oe_d       = oe_q;
    ack_flag_d = ack_flag_q;
    ack_req_d  = ack_req_q;
    rx_d       = rx_q;
    stop_err_d = stop_err_q;
    done       = 1'b0;

    if (phase_q == PH_IDLE) begin
      // command launch, first segment lines applied now
      case (tick_i.cmd)
        CMD_START: begin
          oe_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1;
          phase_d = PH_ST_A; dly_d = 2'd2; presc_d = 8'd0;
        end
        CMD_STOP: begin
          oe_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0; stop_err_d = 1'b0;
          phase_d = PH_SP_A; dly_d = 2'd2; presc_d = 8'd0;
        end
        CMD_WRITE: begin
          oe_d = 1'b1; scl_d = 1'b0; shift_d = tick_i.tx_byte; bit_d = 3'd0;
          phase_d = PH_WR_LO; dly_d = 2'd1; presc_d = 8'd0;
        end
        CMD_READ: begin
          oe_d = 1'b0; scl_d = 1'b0; shift_d = 8'd0; bit_d = 3'd0;
          ack_req_d = tick_i.send_ack;
          phase_d = PH_RD_LO; dly_d = 2'd2; presc_d = 8'd0;
        end
        default: ;
      endcase
    end else if (phase_q == PH_WA_PL) begin
      // ack polling, one sample per tick
      if (!tick_i.sda_in) begin
        scl_d = 1'b0; ack_flag_d = 1'b0;
        phase_d = PH_IDLE; done = 1'b1;
      end else if (poll_next > {1'b0, timeout_q}) begin
        oe_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0; stop_err_d = 1'b1;
        phase_d = PH_SP_A; dly_d = 2'd2; presc_d = 8'd0;
      end else begin
        poll_d = poll_next[7:0];
      end
    end else if ({1'b0, presc_q} + 9'd1 >= {1'b0, ticks_q}) begin
      // end of a delay unit
      presc_d = 8'd0;
      dly_d   = dly_dec;
      if (dly_dec == 2'd0) begin
        case (phase_q)
          PH_ST_A: begin sda_d = 1'b0; phase_d = PH_ST_B; dly_d = 2'd2; end
          PH_ST_B: begin scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1; end
          PH_SP_A: begin scl_d = 1'b1; phase_d = PH_SP_B; dly_d = 2'd1; end
          PH_SP_B: begin sda_d = 1'b1; phase_d = PH_SP_C; dly_d = 2'd2; end
          PH_SP_C: begin
            if (stop_err_q) ack_flag_d = 1'b1;
            stop_err_d = 1'b0;
            phase_d = PH_IDLE; done = 1'b1;
          end
          PH_WR_LO: begin
            sda_d = shift_q[7];
            shift_d = {shift_q[6:0], 1'b0};
            phase_d = PH_WR_DT; dly_d = 2'd1;
          end
          PH_WR_DT: begin scl_d = 1'b1; phase_d = PH_WR_HI; dly_d = 2'd2; end
          PH_WR_HI: begin
            scl_d = 1'b0;
            if (bit_q != 3'd7) begin
              bit_d = bit_q + 3'd1; phase_d = PH_WR_LO; dly_d = 2'd1;
            end else begin
              oe_d = 1'b0; phase_d = PH_WA_LO; dly_d = 2'd1;
            end
          end
          PH_WA_LO: begin scl_d = 1'b1; phase_d = PH_WA_HI; dly_d = 2'd1; end
          PH_WA_HI: begin poll_d = 8'd0; phase_d = PH_WA_PL; end
          PH_RD_LO: begin scl_d = 1'b1; phase_d = PH_RD_HI; dly_d = 2'd2; end
          PH_RD_HI: begin
            shift_d = {shift_q[6:0], tick_i.sda_in};
            scl_d = 1'b0;
            if (bit_q != 3'd7) begin
              bit_d = bit_q + 3'd1; phase_d = PH_RD_LO; dly_d = 2'd2;
            end else begin
              oe_d = 1'b1; sda_d = ~ack_req_q; phase_d = PH_AK_LO; dly_d = 2'd2;
            end
          end
          PH_AK_LO: begin scl_d = 1'b1; phase_d = PH_AK_HI; dly_d = 2'd2; end
          PH_AK_HI: begin
            scl_d = 1'b0; rx_d = shift_q;
            phase_d = PH_IDLE; done = 1'b1;
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end else begin
      presc_d = presc_q + 8'd1;
    end
  end

  // result of this tick
  always_comb begin
    res_o.scl       = scl_d;
    res_o.sda_out   = sda_d;
    res_o.sda_oe    = oe_d;
    res_o.busy_res  = (phase_d != PH_IDLE);
    res_o.done_res  = done;
    res_o.rx_byte   = rx_d;
    res_o.ack_error = ack_flag_d;
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      bit_q      <= 3'd0;
      shift_q    <= 8'd0;
      dly_q      <= 2'd0;
      presc_q    <= 8'd0;
      poll_q     <= 8'd0;
      scl_q      <= 1'b1;
      sda_q      <= 1'b1;
      oe_q       <= 1'b1;
      ack_flag_q <= 1'b0;
      ack_req_q  <= 1'b0;
      rx_q       <= 8'd0;
      stop_err_q <= 1'b0;
    end else if (step) begin
      phase_q    <= phase_d;
      bit_q      <= bit_d;
      shift_q    <= shift_d;
      dly_q      <= dly_d;
      presc_q    <= presc_d;
      poll_q     <= poll_d;
      scl_q      <= scl_d;
      sda_q      <= sda_d;
      oe_q       <= oe_d;
      ack_flag_q <= ack_flag_d;
      ack_req_q  <= ack_req_d;
      rx_q       <= rx_d;
      stop_err_q <= stop_err_d;
    end
  end

endmodule

// File: rtl/i2cm_resq.sv
// ----------------------------------------------------------------------------
// i2cm_resq
// Two-entry result queue between the sequencer and the result port.
// ----------------------------------------------------------------------------
module i2cm_resq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  i2cm_pkg::res_item_t res_i,
  output logic                room_o,
  output logic                empty,
  input  logic                pop,
  output i2cm_pkg::res_item_t res_o
);
  import i2cm_pkg::*;

  res_item_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;

  // a full queue still takes a result in the cycle one leaves
  assign empty  = (cnt_q == 2'd0);
  assign rd_en  = pop && !empty;
  assign room_o = (cnt_q != 2'd2) || rd_en;
  assign wr_en  = push_i && room_o;
  assign res_o  = mem_q[rd_ptr_q];
  assign cnt_d  = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_q <= ~wr_ptr_q;
      if (rd_en) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

// File: rtl/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master bus sequencer driven by one timing tick per input item.
// ----------------------------------------------------------------------------
// Each pushed item is one bus tick; it yields exactly one result holding the
// SCL/SDA drive and status after that tick. The engine takes one tick per
// clock and delivers one result per clock while the result side keeps
// popping: the sequencer step is a registered update of the phase state,
// and a pushed tick is registered in the input queue and then in the result
// queue before it shows up on the result ports. Both queues hold two entries,
// so either side may stall without losing ticks. Commands (start, stop,
// write, read) are honored only on ticks where the sequencer is idle.
// Configuration writes are always ready and take effect on the next tick;
// index 0 is ticks per delay unit, index 1 the ACK poll timeout.
module i2c_master_byte_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  i2cm_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output i2cm_pkg::res_item_t res_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i
);
  import i2cm_pkg::*;

  logic      tick_valid, tick_take, res_room, res_push;
  tick_t     tick;
  res_item_t res_new;
  cfg_wr_t   cfg_wr;

  // configuration channel
  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  // front: accept and decode
  i2cm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .item_i       (in_item_i),
    .tick_valid_o (tick_valid),
    .tick_o       (tick),
    .tick_take_i  (tick_take)
  );

  // back: bus sequencer
  i2cm_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_wr),
    .tick_valid_i (tick_valid),
    .tick_i       (tick),
    .tick_take_o  (tick_take),
    .res_room_i   (res_room),
    .res_push_o   (res_push),
    .res_o        (res_new)
  );

  // result queue
  i2cm_resq u_resq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .res_i  (res_new),
    .room_o (res_room),
    .empty  (empty),
    .pop    (pop),
    .res_o  (res_item_o)
  );

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Tick-by-tick check of the I2C master byte engine.
// Every pushed tick is run through a line-state predictor kept in a small
// scoreboard; each popped result is compared field by field with the oldest
// prediction. Stimulus is a short directed pass followed by random
// start/write/read/stop transfers under several prescaler and ACK timeout
// settings, with random stalls on both queue sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import i2cm_pkg::*;

// line-state predictor and store of expected results
class i2c_line_scoreboard;
  logic [7:0] tpu;
  logic [7:0] tmo;
  phase_e     ph;
  logic [3:0] bit_idx;
  logic [7:0] shreg;
  logic [7:0] units_left;
  logic [7:0] pre_cnt;
  logic [7:0] polls;
  logic       scl;
  logic       sda;
  logic       oe;
  logic       ack_err;
  logic       ack_want;
  logic       stop_err;
  logic [7:0] rx_last;
  res_item_t  expected_lines[$];
  int         errors;

  function new();
    tpu        = TICKS_PER_UNIT_RST;
    tmo        = ACK_TIMEOUT_RST;
    ph         = PH_IDLE;
    bit_idx    = '0;
    shreg      = '0;
    units_left = '0;
    pre_cnt    = '0;
    polls      = '0;
    scl        = 1'b1;
    sda        = 1'b1;
    oe         = 1'b1;
    ack_err    = 1'b0;
    ack_want   = 1'b0;
    stop_err   = 1'b0;
    rx_last    = '0;
    errors     = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [7:0] val);
    if (idx == CFG_TICKS_PER_UNIT) begin
      tpu = val;
    end else if (idx == CFG_ACK_TIMEOUT) begin
      tmo = val;
    end
  endfunction

  function bit is_idle();
    return ph == PH_IDLE;
  endfunction

  function bit in_poll();
    return ph == PH_WA_PL;
  endfunction

  function int pending();
    return expected_lines.size();
  endfunction

  function void enter_seg(phase_e p, logic [7:0] units);
    ph         = p;
    units_left = units;
    pre_cnt    = '0;
  endfunction

  // end of a timed segment: move to the next one, 1 when the command is done
  function bit end_segment();
    bit fin;
    fin = 1'b0;
    case (ph)
      PH_ST_A: begin
        sda = 1'b0;
        enter_seg(PH_ST_B, 8'd2);
      end
      PH_ST_B: begin
        scl = 1'b0;
        ph  = PH_IDLE;
        fin = 1'b1;
      end
      PH_SP_A: begin
        scl = 1'b1;
        enter_seg(PH_SP_B, 8'd1);
      end
      PH_SP_B: begin
        sda = 1'b1;
        enter_seg(PH_SP_C, 8'd2);
      end
      PH_SP_C: begin
        if (stop_err) ack_err = 1'b1;
        stop_err = 1'b0;
        ph       = PH_IDLE;
        fin      = 1'b1;
      end
      PH_WR_LO: begin
        sda   = shreg[7];
        shreg = {shreg[6:0], 1'b0};
        enter_seg(PH_WR_DT, 8'd1);
      end
      PH_WR_DT: begin
        scl = 1'b1;
        enter_seg(PH_WR_HI, 8'd2);
      end
      PH_WR_HI: begin
        scl = 1'b0;
        if (bit_idx < 4'd7) begin
          bit_idx++;
          enter_seg(PH_WR_LO, 8'd1);
        end else begin
          oe = 1'b0;
          enter_seg(PH_WA_LO, 8'd1);
        end
      end
      PH_WA_LO: begin
        scl = 1'b1;
        enter_seg(PH_WA_HI, 8'd1);
      end
      PH_WA_HI: begin
        polls = '0;
        ph    = PH_WA_PL;
      end
      PH_RD_LO: begin
        scl = 1'b1;
        enter_seg(PH_RD_HI, 8'd2);
      end
      PH_AK_LO: begin
        scl = 1'b1;
        enter_seg(PH_AK_HI, 8'd2);
      end
      PH_AK_HI: begin
        scl     = 1'b0;
        rx_last = shreg;
        ph      = PH_IDLE;
        fin     = 1'b1;
      end
      default: ph = PH_IDLE;
    endcase
    return fin;
  endfunction

  // advance the bus state by one tick and return the line state after it
  function res_item_t predict_lines(in_item_t it);
    res_item_t  r;
    bit         fin;
    logic [8:0] nxt;
    fin = 1'b0;
    if (ph == PH_IDLE) begin
      case (it.op)
        OP_START: begin
          oe  = 1'b1;
          sda = 1'b1;
          scl = 1'b1;
          enter_seg(PH_ST_A, 8'd2);
        end
        OP_STOP: begin
          oe       = 1'b1;
          scl      = 1'b0;
          sda      = 1'b0;
          stop_err = 1'b0;
          enter_seg(PH_SP_A, 8'd2);
        end
        OP_WRITE: begin
          oe      = 1'b1;
          scl     = 1'b0;
          shreg   = it.tx_byte;
          bit_idx = '0;
          enter_seg(PH_WR_LO, 8'd1);
        end
        OP_READ: begin
          oe       = 1'b0;
          scl      = 1'b0;
          shreg    = '0;
          bit_idx  = '0;
          ack_want = it.send_ack;
          enter_seg(PH_RD_LO, 8'd2);
        end
        default: ;
      endcase
    end else if (ph == PH_WA_PL) begin
      // one ack sample per tick, timeout count compared at 9 bits
      if (!it.sda_in) begin
        scl     = 1'b0;
        ack_err = 1'b0;
        ph      = PH_IDLE;
        fin     = 1'b1;
      end else begin
        nxt = {1'b0, polls} + 9'd1;
        if (nxt > {1'b0, tmo}) begin
          oe       = 1'b1;
          scl      = 1'b0;
          sda      = 1'b0;
          stop_err = 1'b1;
          enter_seg(PH_SP_A, 8'd2);
        end else begin
          polls = nxt[7:0];
        end
      end
    end else begin
      // prescaled segment countdown, zero prescaler acts as one
      if ({1'b0, pre_cnt} + 9'd1 >= {1'b0, tpu}) begin
        pre_cnt = '0;
        if (units_left != 8'd0) units_left--;
        if (units_left == 8'd0) begin
          if (ph == PH_RD_HI) begin
            shreg = {shreg[6:0], it.sda_in};
            scl   = 1'b0;
            if (bit_idx < 4'd7) begin
              bit_idx++;
              enter_seg(PH_RD_LO, 8'd2);
            end else begin
              oe  = 1'b1;
              sda = ~ack_want;
              enter_seg(PH_AK_LO, 8'd2);
            end
          end else begin
            fin = end_segment();
          end
        end
      end else begin
        pre_cnt++;
      end
    end
    r.scl       = scl;
    r.sda_out   = sda;
    r.sda_oe    = oe;
    r.busy_res  = (ph != PH_IDLE);
    r.done_res  = fin;
    r.rx_byte   = rx_last;
    r.ack_error = ack_err;
    return r;
  endfunction

  function void note_tick(in_item_t it);
    expected_lines.push_back(predict_lines(it));
  endfunction

  function void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(res_item_t got);
    res_item_t want;
    if (expected_lines.size() == 0) begin
      $error("result with no tick pending: %p", got);
      errors++;
      return;
    end
    want = expected_lines.pop_front();
    check_field("scl", 8'(want.scl), 8'(got.scl));
    check_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
    check_field("sda_oe", 8'(want.sda_oe), 8'(got.sda_oe));
    check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
    check_field("done_res", 8'(want.done_res), 8'(got.done_res));
    check_field("rx_byte", want.rx_byte, got.rx_byte);
    check_field("ack_error", 8'(want.ack_error), 8'(got.ack_error));
  endfunction
endclass

module tb_top;

  // op codes the block does not define, handled as plain ticks
  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;

  // sda_in pattern outside ack polling
  localparam int SDA_RAND = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_LOW  = 2;

  localparam int NO_ACK    = -1;
  localparam int LIMIT     = 1000000;
  localparam int LONG_HOLD = 300;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  in_item_t    in_item_i   = '0;
  logic        empty;
  logic        pop         = 1'b0;
  res_item_t   res_item_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i  = '0;

  i2c_line_scoreboard board;
  int          ticks_sent   = 0;
  int          results_seen = 0;
  int          cycles       = 0;
  int          hold_cnt     = 0;
  bit          long_hold_done = 1'b0;
  bit          calm         = 1'b0;

  i2c_master_byte_engine i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .res_item_o (res_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: check every transfer out
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      board.check_result(res_item_o);
      results_seen <= results_seen + 1;
    end
  end

  // result side: random stall bursts, one long hold-off to fill the block
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_cnt != 0) begin
      pop      <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (!long_hold_done && results_seen >= 500) begin
      pop            <= 1'b0;
      hold_cnt       <= LONG_HOLD - 1;
      long_hold_done <= 1'b1;
    end else if (!calm && ((cycles / 256) % 2 == 0) && $urandom_range(0, 5) == 0) begin
      pop      <= 1'b0;
      hold_cnt <= $urandom_range(0, 11);
    end else begin
      pop <= 1'b1;
    end
  end

  // one tick transfer in, at times with a random gap ahead of it
  task automatic send_tick(input in_item_t it);
    int gap;
    if (!calm && ((ticks_sent / 128) % 2 == 0) && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk_i);
        push <= 1'b0;
      end
    end
    @(negedge clk_i);
    push      <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    board.note_tick(it);
    ticks_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    push <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_item_t noise_tick(int sda_mode);
    in_item_t it;
    it.op       = 3'($urandom_range(OP_TICK, OP_RSVD_HI));
    it.tx_byte  = 8'($urandom);
    it.send_ack = 1'($urandom_range(0, 1));
    case (sda_mode)
      SDA_HIGH: it.sda_in = 1'b1;
      SDA_LOW:  it.sda_in = 1'b0;
      default:  it.sda_in = 1'($urandom_range(0, 1));
    endcase
    return it;
  endfunction

  // issue one command from idle and tick until the sequencer is idle again;
  // commands sent meanwhile are noise the block must ignore
  task automatic run_cmd(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                         input int ack_after, input int sda_mode);
    in_item_t it;
    int       polled;
    polled      = 0;
    it          = noise_tick(sda_mode);
    it.op       = op;
    it.tx_byte  = tx;
    it.send_ack = ack;
    send_tick(it);
    while (!board.is_idle()) begin
      it = noise_tick(sda_mode);
      if (board.in_poll()) begin
        it.sda_in = (ack_after == NO_ACK) || (polled < ack_after);
        polled++;
      end
      send_tick(it);
    end
  endtask

  function automatic int pick_ack();
    if ($urandom_range(0, 9) == 0) return NO_ACK;
    return $urandom_range(0, 3);
  endfunction

  // mostly well-formed transfers, some stray commands
  task automatic random_transfer();
    int n;
    if ($urandom_range(0, 4) != 0) begin
      run_cmd(OP_START, 8'($urandom), 1'($urandom_range(0, 1)), 0, SDA_RAND);
      n = $urandom_range(1, 3);
      repeat (n) begin
        if ($urandom_range(0, 1)) begin
          run_cmd(OP_WRITE, 8'($urandom), 1'($urandom_range(0, 1)), pick_ack(),
                  SDA_RAND);
        end else begin
          run_cmd(OP_READ, 8'($urandom), 1'($urandom_range(0, 1)), 0, SDA_RAND);
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        run_cmd(OP_STOP, 8'($urandom), 1'($urandom_range(0, 1)), 0, SDA_RAND);
      end
    end else begin
      run_cmd(3'($urandom_range(OP_TICK, OP_RSVD_HI)), 8'($urandom),
              1'($urandom_range(0, 1)), pick_ack(), SDA_RAND);
    end
    n = $urandom_range(0, 3);
    repeat (n) begin
      if ($urandom_range(0, 1)) begin
        run_cmd(OP_TICK, 8'($urandom), 1'($urandom_range(0, 1)), 0, SDA_RAND);
      end else begin
        run_cmd(3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)), 8'($urandom),
                1'($urandom_range(0, 1)), 0, SDA_RAND);
      end
    end
  endtask

  // main sequence
  initial begin
    int         target;
    int         waited;
    int         errs;
    logic [7:0] tpu;
    logic [7:0] tmo;
    board = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed pass at reset settings
    run_cmd(OP_TICK, 8'h00, 1'b0, 0, SDA_LOW);
    for (int op = OP_RSVD_LO; op <= OP_RSVD_HI; op++) begin
      run_cmd(3'(op), 8'hFF, 1'b1, 0, SDA_HIGH);
    end
    run_cmd(OP_STOP, 8'h00, 1'b0, 0, SDA_RAND);
    run_cmd(OP_START, 8'h00, 1'b0, 0, SDA_RAND);
    run_cmd(OP_WRITE, 8'hFF, 1'b0, 0, SDA_RAND);
    run_cmd(OP_WRITE, 8'h00, 1'b1, 3, SDA_RAND);
    run_cmd(OP_READ, 8'h00, 1'b1, 0, SDA_HIGH);
    run_cmd(OP_READ, 8'hFF, 1'b0, 0, SDA_LOW);
    run_cmd(OP_READ, 8'h5A, 1'b1, 0, SDA_RAND);
    run_cmd(OP_WRITE, 8'hA5, 1'b0, NO_ACK, SDA_RAND);
    run_cmd(OP_STOP, 8'h00, 1'b0, 0, SDA_RAND);

    // zero prescaler, longest ack timeout
    wait_drained();
    write_reg(CFG_TICKS_PER_UNIT, 8'd0);
    write_reg(CFG_ACK_TIMEOUT, 8'd255);
    run_cmd(OP_START, 8'h00, 1'b0, 0, SDA_RAND);
    run_cmd(OP_WRITE, 8'h81, 1'b0, NO_ACK, SDA_RAND);
    run_cmd(OP_STOP, 8'h00, 1'b0, 0, SDA_RAND);

    // slowest prescaler, ACK timeout of 1
    wait_drained();
    write_reg(CFG_TICKS_PER_UNIT, 8'd255);
    write_reg(CFG_ACK_TIMEOUT, 8'd1);
    run_cmd(OP_START, 8'h00, 1'b0, 0, SDA_RAND);

    // random transfers under several settings
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      case ($urandom_range(0, 5))
        0:       tpu = 8'd0;
        1, 2:    tpu = 8'd1;
        3:       tpu = 8'd2;
        4:       tpu = 8'd3;
        default: tpu = 8'($urandom_range(4, 8));
      endcase
      case ($urandom_range(0, 5))
        4:       tmo = 8'd250;
        5:       tmo = 8'd255;
        default: tmo = 8'($urandom_range(0, 8));
      endcase
      write_reg(CFG_TICKS_PER_UNIT, tpu);
      write_reg(CFG_ACK_TIMEOUT, tmo);
      target = ticks_sent + 80;
      while (ticks_sent < target) random_transfer();
    end

    // closing stretch with no stalls on either side
    wait_drained();
    calm = 1'b1;
    write_reg(CFG_TICKS_PER_UNIT, 8'd1);
    write_reg(CFG_ACK_TIMEOUT, 8'd3);
    target = ticks_sent + 100;
    while (ticks_sent < target) random_transfer();

    @(negedge clk_i);
    push <= 1'b0;
    waited = 0;
    while (board.pending() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    errs = board.errors;
    if (board.pending() != 0) begin
      $error("%0d expected results never arrived", board.pending());
      errs++;
    end
    if (errs == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/i2cm_pkg.sv
rtl/i2cm_front.sv
rtl/i2cm_seq.sv
rtl/i2cm_resq.sv
rtl/i2c_master_byte_engine.sv
test/tb_top.sv
